// ===== sv/rgb_conv3x3_filter_top_defines.svh =====
// Assertion macros for the checker file of the RGB 3x3 filter.
// Needs no other file; pulled in by `include where assertions are written.
`ifndef RGB_CONV3X3_FILTER_TOP_DEFINES_SVH
`define RGB_CONV3X3_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RGBC3_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbc3 check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define RGBC3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbc3 check failed: next-cycle implication");

`endif

// ===== sv/rgbc3_pkg.sv =====
// Shared types, constants and arithmetic helpers of the RGB 3x3 filter.
// No dependencies; imported by every module of the block but rgbc3_ram.
package rgbc3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;
    localparam int DIM_MAX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int LIM_W      = (DIM_MAX_W + 1 > SIZE_W) ? DIM_MAX_W + 1 : SIZE_W;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int COEF_W     = 3 * CH_W;
    localparam int PROD_W     = 16;
    localparam int RSUM_W     = 18;
    localparam int SUM_W      = 20;
    localparam int FRAC_W     = 4;

    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT      = 3'd4;

    localparam logic [COEF_W-1:0] COEF_TOP_RST    = 24'h000000;
    localparam logic [COEF_W-1:0] COEF_MID_RST    = 24'h001000;
    localparam logic [COEF_W-1:0] COEF_BOTTOM_RST = 24'h000000;
    localparam logic [SIZE_W-1:0] WIDTH_RST       = 11'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST      = 11'd400;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            row_end;
        logic            frame_end;
    } pix_out_t;

    // One pixel leaving the line buffer stage toward the window.
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             last_col;
        logic             last_row;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] above2;
    } lb_tap_t;

    // Last valid index for a configured size, size clamped to 3..max_size.
    function automatic logic [LIM_W-1:0] last_index(input logic [SIZE_W-1:0] size,
                                                    input logic [LIM_W-1:0]  max_size);
        logic [LIM_W-1:0] s;
        s = LIM_W'(size);
        if (s < LIM_W'(3))
            s = LIM_W'(3);
        else if (s > max_size)
            s = max_size;
        return s - LIM_W'(1);
    endfunction

    // Unsigned sample times signed Q4.4 coefficient.
    function automatic logic signed [PROD_W-1:0] tap_mul(input logic [CH_W-1:0] p,
                                                         input logic [CH_W-1:0] k);
        logic signed [PROD_W:0] full;
        full = $signed({1'b0, p}) * $signed(k);
        return full[PROD_W-1:0];
    endfunction

    // Drop the fraction and saturate to 0..255.
    function automatic logic [CH_W-1:0] sat_pix(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-FRAC_W-1:0] q;
        logic [CH_W-1:0]                r;
        q = s[SUM_W-1:FRAC_W];
        if (s < 0)
            r = '0;
        else if (q > $signed((SUM_W-FRAC_W)'(2**CH_W - 1)))
            r = '1;
        else
            r = q[CH_W-1:0];
        return r;
    endfunction

endpackage

// ===== sv/rgbc3_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rgbc3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ===== sv/rgbc3_linebuf.sv =====
// Raster counters and the two line stores of the RGB 3x3 filter.
// Depends on rgbc3_pkg and rgbc3_ram.
module rgbc3_linebuf
    import rgbc3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] image_width,
    input  logic [SIZE_W-1:0] image_height,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  pix_in_t           pix_data,
    output lb_tap_t           tap,
    input  logic              tap_ready
);

    logic [COL_W-1:0] col_reg, col_next, col, col_last;
    logic [ROW_W-1:0] row_reg, row_next, row, row_last;
    logic             v1_reg, emit1_reg, lc1_reg, lr1_reg;
    logic [PIX_W-1:0] px1_reg;
    logic [COL_W-1:0] col1_reg;
    logic             ready, accept, wr_en;
    logic             emit, last_col, last_row;
    logic [PIX_W-1:0] above, above2;

    assign col_last = COL_W'(last_index(image_width, LIM_W'(MAX_WIDTH)));
    assign row_last = ROW_W'(last_index(image_height, LIM_W'(MAX_HEIGHT)));

    // Counters past a shrunken size count as the last column or line.
    assign col = (col_reg > col_last) ? col_last : col_reg;
    assign row = (row_reg > row_last) ? row_last : row_reg;

    assign emit     = (row >= ROW_W'(2)) && (col >= COL_W'(2));
    assign last_col = (col == col_last);
    assign last_row = (row == row_last);

    assign ready     = !v1_reg || tap_ready;
    assign pix_stall = !ready;
    assign accept    = pix_valid && ready;
    assign wr_en     = v1_reg && tap_ready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row + ROW_W'(1);
            end
            else
            begin
                col_next = col + COL_W'(1);
                row_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (ready)
                v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px1_reg   <= {pix_data.blue_in, pix_data.green_in, pix_data.red_in};
            col1_reg  <= col;
            emit1_reg <= emit;
            lc1_reg   <= last_col;
            lr1_reg   <= last_row;
        end
    end

    // Read both lines at accept, write back when the pixel moves on.
    rgbc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (col1_reg),
        .wdata (px1_reg),
        .re    (accept),
        .raddr (col),
        .rdata (above)
    );

    rgbc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (col1_reg),
        .wdata (above),
        .re    (accept),
        .raddr (col),
        .rdata (above2)
    );

    assign tap.valid    = v1_reg;
    assign tap.emit     = emit1_reg;
    assign tap.last_col = lc1_reg;
    assign tap.last_row = lr1_reg;
    assign tap.px       = px1_reg;
    assign tap.above    = above;
    assign tap.above2   = above2;

endmodule

// ===== sv/rgbc3_mac.sv =====
// 3x3 window, products, row sums and output register of the RGB 3x3 filter.
// Depends on rgbc3_pkg.
module rgbc3_mac
    import rgbc3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [COEF_W-1:0] coef_row_top,
    input  logic [COEF_W-1:0] coef_row_mid,
    input  logic [COEF_W-1:0] coef_row_bottom,
    input  lb_tap_t           tap,
    output logic              tap_ready,
    output logic              res_valid,
    input  logic              res_stall,
    output pix_out_t          res_data
);

    logic [PIX_W-1:0]         win_reg [3][3];
    logic signed [PROD_W-1:0] prod_reg [3][3][3];
    logic signed [PROD_W-1:0] prod_next [3][3][3];
    logic signed [RSUM_W-1:0] rsum_reg [3][3];
    logic signed [RSUM_W-1:0] rsum_next [3][3];
    logic signed [SUM_W-1:0]  total [3];
    logic [COEF_W-1:0]        coefs [3];
    logic                     v2_reg, v3_reg, v4_reg, vo_reg;
    logic                     re2_reg, re3_reg, re4_reg;
    logic                     fe2_reg, fe3_reg, fe4_reg;
    pix_out_t                 out_reg;
    logic                     ready_o, ready4, ready3, ready2, take;

    assign ready_o   = !vo_reg || !res_stall;
    assign ready4    = !v4_reg || ready_o;
    assign ready3    = !v3_reg || ready4;
    assign ready2    = !v2_reg || ready3;
    assign tap_ready = ready2;
    assign take      = tap.valid && ready2;

    assign coefs[0] = coef_row_top;
    assign coefs[1] = coef_row_mid;
    assign coefs[2] = coef_row_bottom;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                    prod_next[ch][r][c] = tap_mul(win_reg[r][c][ch*CH_W +: CH_W],
                                                  coefs[r][c*CH_W +: CH_W]);
                rsum_next[ch][r] = RSUM_W'(prod_reg[ch][r][0]) +
                                   RSUM_W'(prod_reg[ch][r][1]) +
                                   RSUM_W'(prod_reg[ch][r][2]);
            end
            total[ch] = SUM_W'(rsum_reg[ch][0]) + SUM_W'(rsum_reg[ch][1]) +
                        SUM_W'(rsum_reg[ch][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else
        begin
            if (ready2)
                v2_reg <= take && tap.emit;
            if (ready3)
                v3_reg <= v2_reg;
            if (ready4)
                v4_reg <= v3_reg;
            if (ready_o)
                vo_reg <= v4_reg;
            // Every pixel shifts the window, result or not.
            if (take)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= tap.above2;
                win_reg[1][2] <= tap.above;
                win_reg[2][2] <= tap.px;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            re2_reg <= tap.last_col;
            fe2_reg <= tap.last_col && tap.last_row;
        end
        if (ready3)
        begin
            prod_reg <= prod_next;
            re3_reg  <= re2_reg;
            fe3_reg  <= fe2_reg;
        end
        if (ready4)
        begin
            rsum_reg <= rsum_next;
            re4_reg  <= re3_reg;
            fe4_reg  <= fe3_reg;
        end
        if (ready_o)
        begin
            out_reg.red_out   <= sat_pix(total[0]);
            out_reg.green_out <= sat_pix(total[1]);
            out_reg.blue_out  <= sat_pix(total[2]);
            out_reg.row_end   <= re4_reg;
            out_reg.frame_end <= fe4_reg;
        end
    end

    assign res_valid = vo_reg;
    assign res_data  = out_reg;

endmodule

// ===== sv/rgb_conv3x3_filter_top.sv =====
// Top level of the streaming RGB 3x3 convolution filter.
// Depends on rgbc3_pkg, rgbc3_linebuf, rgbc3_mac (and rgbc3_ram below them).
//
//  Channel   Signals                          Direction  Moves
//  -------   -------------------------------  ---------  ------------------------------
//  pixel     pix_valid / pix_stall / pix_data  in         one raster RGB pixel per transfer
//  result    res_valid / res_stall / res_data  out        one filtered interior pixel
//  config    cfg_wr_en / cfg_index / cfg_wdata in         one register write, no read-back
//
// One pixel is taken every clock while pix_stall is low; each result passes the line
// buffer, window, product, row-sum and output registers. The line stores have one read
// and one write port each, and every pixel reads and writes them once, which sets the
// rate of one pixel per clock when nothing stalls. Reset clears counters, window and
// pipeline valids; line stores are not cleared and need no clearing pass. A stalled result
// holds in the output register while empty pipeline stages keep filling; pix_stall rises
// only once the line buffer stage holds a pixel and every later stage a result.
module rgb_conv3x3_filter_top
    import rgbc3_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  pix_in_t              pix_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output pix_out_t             res_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_wdata
);

    // Configuration registers; user writes only while pipeline is empty, unenforced.
    logic [COEF_W-1:0] coef_top_reg, coef_mid_reg, coef_bottom_reg;
    logic [SIZE_W-1:0] width_reg, height_reg;

    // Line buffer to window handshake.
    lb_tap_t tap;
    logic    tap_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg    <= COEF_TOP_RST;
            coef_mid_reg    <= COEF_MID_RST;
            coef_bottom_reg <= COEF_BOTTOM_RST;
            width_reg       <= WIDTH_RST;
            height_reg      <= HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_COEF_TOP:    coef_top_reg    <= cfg_wdata;
                CFG_COEF_MID:    coef_mid_reg    <= cfg_wdata;
                CFG_COEF_BOTTOM: coef_bottom_reg <= cfg_wdata;
                CFG_WIDTH:       width_reg       <= cfg_wdata[SIZE_W-1:0];
                CFG_HEIGHT:      height_reg      <= cfg_wdata[SIZE_W-1:0];
                default:         ; // drop writes to unknown indexes
            endcase
        end
    end

    // Raster position, line store read/modify/write, one pixel per transfer.
    rgbc3_linebuf u_linebuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .pix_data     (pix_data),
        .tap          (tap),
        .tap_ready    (tap_ready)
    );

    // Window shift, products, row sums, saturation and output register.
    rgbc3_mac u_mac (
        .clk             (clk),
        .rst_n           (rst_n),
        .coef_row_top    (coef_top_reg),
        .coef_row_mid    (coef_mid_reg),
        .coef_row_bottom (coef_bottom_reg),
        .tap             (tap),
        .tap_ready       (tap_ready),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res_data        (res_data)
    );

endmodule

// ===== sv/rgbc3_checker.sv =====
// Port-level checks of the RGB 3x3 filter and the bind that attaches them.
// Depends on rgbc3_pkg and rgb_conv3x3_filter_top_defines.svh.
`include "rgb_conv3x3_filter_top_defines.svh"

module rgbc3_checker
    import rgbc3_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     pix_stall,
    input logic     res_valid,
    input logic     res_stall,
    input pix_out_t res_data
);

    // A stalled result holds until its transfer.
    `RGBC3_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(res_data))

    // The frame's last result is also the last of its row.
    `RGBC3_ASSERT_IMPLY(a_frame_row, clk, rst_n, res_valid && res_data.frame_end, res_data.row_end)

    // With the output register empty every stage can advance, so input is open.
    `RGBC3_ASSERT_IMPLY(a_no_stall_empty, clk, rst_n, !res_valid, !pix_stall)

    // Two results in a row cannot both close the frame.
    `RGBC3_ASSERT_NEXT(a_frame_once, clk, rst_n, res_valid && !res_stall && res_data.frame_end, !(res_valid && res_data.frame_end))

endmodule

bind rgb_conv3x3_filter_top rgbc3_checker u_rgbc3_checker (.*);
